### rtl/core/assert_macros.svh
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/sics_pkg.sv
package sics_pkg;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_CUT   = 2'd1,
    PH_COOL  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CFG_CUT_TIME     = 2'd0,
    CFG_COOLDOWN     = 2'd1,
    CFG_MIN_SPEED    = 2'd2,
    CFG_MIN_THROTTLE = 2'd3
  } cfg_idx_t;

  // 65535 ms * 10000 ticks fits in 30 bits
  localparam int unsigned TICK_W = 30;

  localparam logic [7:0]        SENSE_LIMIT  = 8'h10;
  localparam logic [7:0]        CUT_MASK     = 8'h03;
  localparam logic [7:0]        GEAR_LIMIT   = 8'd6;
  localparam logic [13:0]       TICKS_PER_MS = 14'd10000;
  localparam logic [TICK_W-1:0] CUT_TICKS_RST  = TICK_W'(700000);
  localparam logic [TICK_W-1:0] COOL_TICKS_RST = TICK_W'(3000000);
  localparam logic [15:0]       MIN_SPEED_RST  = 16'd7680;
  localparam logic [7:0]        MIN_THR_RST    = 8'd0;

endpackage

### rtl/core/shift_ignition_cut_sequencer.sv
// Path: an accepted input goes to the input register, then the result register.
// Throughput: one request per cycle while out_ready holds; the phase/timestamp
// update is a single stage between the input register and the result register.
// Reset (rst_n low, synchronous): phase READY, timestamps cleared, pipeline
// empty, configuration back to 70 ms cut, 300 ms cooldown, speed 7680, throttle 0.
module shift_ignition_cut_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_engine_speed,
  input  logic [7:0]  in_throttle,
  input  logic [7:0]  in_gear,
  input  logic [7:0]  in_sensor_voltage,
  input  logic [31:0] in_timer_now,
  input  logic [7:0]  in_limit_flags_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_limit_flags_out,
  output logic [1:0]  out_phase,
  input  logic        cfg_we,
  input  sics_pkg::cfg_idx_t cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sics_pkg::*;

  `include "assert_macros.svh"

  // configuration, durations stored already scaled to timer ticks
  logic [TICK_W-1:0] cut_cfg_ticks_r;
  logic [TICK_W-1:0] cool_ticks_r;
  logic [15:0]       min_speed_r;
  logic [7:0]        min_throttle_r;
  logic [TICK_W-1:0] wdata_ticks;

  // input register
  logic        s1_valid_r;
  logic [15:0] s1_speed_r;
  logic [7:0]  s1_throttle_r;
  logic [7:0]  s1_gear_r;
  logic [7:0]  s1_volt_r;
  logic [31:0] s1_now_r;
  logic [7:0]  s1_flags_r;

  // sequencer state
  phase_t            phase_r, phase_nxt;
  logic [31:0]       start_r, start_nxt;
  logic [TICK_W-1:0] cut_ticks_r, cut_ticks_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_flags_r;
  logic [1:0] out_phase_r;

  logic              adv;
  logic              request;
  logic              qualify;
  logic [31:0]       elapsed;
  logic [TICK_W-1:0] limit_sel;
  logic              expired;
  logic [7:0]        flags_nxt;

  assign wdata_ticks = TICK_W'(cfg_wdata) * TICK_W'(TICKS_PER_MS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_cfg_ticks_r <= CUT_TICKS_RST;
      cool_ticks_r    <= COOL_TICKS_RST;
      min_speed_r     <= MIN_SPEED_RST;
      min_throttle_r  <= MIN_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUT_TIME:     cut_cfg_ticks_r <= wdata_ticks;
        CFG_COOLDOWN:     cool_ticks_r    <= wdata_ticks;
        CFG_MIN_SPEED:    min_speed_r     <= cfg_wdata;
        CFG_MIN_THROTTLE: min_throttle_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_speed_r    <= in_engine_speed;
      s1_throttle_r <= in_throttle;
      s1_gear_r     <= in_gear;
      s1_volt_r     <= in_sensor_voltage;
      s1_now_r      <= in_timer_now;
      s1_flags_r    <= in_limit_flags_in;
    end
  end

  assign request = s1_volt_r < SENSE_LIMIT;
  assign qualify = (s1_speed_r > min_speed_r) && (s1_gear_r < GEAR_LIMIT) &&
                   (s1_throttle_r >= min_throttle_r);

  // one wrapped-elapsed compare serves whichever timed phase is active
  assign elapsed   = s1_now_r - start_r;
  assign limit_sel = (phase_r == PH_CUT) ? cut_ticks_r : cool_ticks_r;
  assign expired   = elapsed > 32'(limit_sel);

  // next phase; a phase entered from READY cannot expire on the same tick
  always_comb begin
    case (phase_r)
      PH_CUT:  phase_nxt = expired ? PH_COOL : PH_CUT;
      PH_COOL: phase_nxt = expired ? PH_READY : PH_COOL;
      default: begin
        if (request) begin
          phase_nxt = qualify ? PH_CUT : PH_COOL;
        end else begin
          phase_nxt = PH_READY;
        end
      end
    endcase
  end

  always_comb begin
    start_nxt     = start_r;
    cut_ticks_nxt = cut_ticks_r;
    flags_nxt     = s1_flags_r;
    case (phase_r)
      PH_CUT: begin
        if (expired) begin
          flags_nxt = s1_flags_r & ~CUT_MASK;
          start_nxt = s1_now_r;
        end else begin
          flags_nxt = s1_flags_r | CUT_MASK;
        end
      end
      PH_COOL: ;
      default: begin
        if (request) begin
          start_nxt = s1_now_r;
          if (qualify) begin
            flags_nxt     = s1_flags_r | CUT_MASK;
            cut_ticks_nxt = cut_cfg_ticks_r;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_READY;
      start_r     <= '0;
      cut_ticks_r <= '0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      cut_ticks_r <= cut_ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_flags_r <= flags_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_limit_flags_out = out_flags_r;
  assign out_phase           = out_phase_r;

  `ASSERT_IMPL(a_stall_only_when_full, !in_ready, s1_valid_r && out_valid_r && !out_ready)
  `ASSERT_IMPL(a_cut_exits_to_cool, adv && phase_r == PH_CUT,
               phase_nxt == PH_CUT || phase_nxt == PH_COOL)
  `ASSERT_NEXT(a_cut_start_stamp, adv && phase_r == PH_READY && phase_nxt == PH_CUT,
               start_r == $past(s1_now_r) && phase_r == PH_CUT)
  `ASSERT_IMPL(a_cut_flags_set, out_valid_r && out_phase_r == PH_CUT,
               out_flags_r[1:0] == CUT_MASK[1:0])

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import sics_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [15:0] speed;
    logic [7:0]  tps;
    logic [7:0]  gear;
    logic [7:0]  volt;
    logic [31:0] now;
    logic [7:0]  flags;
  } tick_t;

  typedef struct {
    logic [7:0] flags;
    phase_t     phase;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_engine_speed = '0;
  logic [7:0]  in_throttle = '0;
  logic [7:0]  in_gear = '0;
  logic [7:0]  in_sensor_voltage = '0;
  logic [31:0] in_timer_now = '0;
  logic [7:0]  in_limit_flags_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_limit_flags_out;
  logic [1:0]  out_phase;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_CUT_TIME;
  logic [15:0] cfg_wdata = '0;

  shift_ignition_cut_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_engine_speed     (in_engine_speed),
    .in_throttle         (in_throttle),
    .in_gear             (in_gear),
    .in_sensor_voltage   (in_sensor_voltage),
    .in_timer_now        (in_timer_now),
    .in_limit_flags_in   (in_limit_flags_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_limit_flags_out (out_limit_flags_out),
    .out_phase           (out_phase),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  // register shadow
  logic [15:0] cfg_cut_ms = 16'd70;
  logic [15:0] cfg_cool_ms = 16'd300;
  logic [15:0] cfg_min_spd = 16'd7680;
  logic [7:0]  cfg_min_thr = 8'd0;

  // sequencer shadow state
  phase_t      seq_phase = PH_READY;
  logic [31:0] cut_t0 = '0;
  logic [31:0] cool_t0 = '0;
  logic [31:0] cut_len = '0;

  tick_t    tick_q[$];
  outcome_t outcome_q[$];
  logic [31:0] gen_now = 32'hFFFF_F000;

  int err_cnt = 0;
  int res_cnt = 0;
  int cycles = 0;

  function automatic void sequence_tick(input tick_t t);
    outcome_t    o;
    logic [31:0] elapsed;
    logic [31:0] cool_len;
    o.flags = t.flags;
    if (seq_phase == PH_READY && t.volt < SENSE_LIMIT) begin
      if (t.speed > cfg_min_spd && t.gear < GEAR_LIMIT && t.tps >= cfg_min_thr) begin
        seq_phase = PH_CUT;
        cut_t0 = t.now;
        cut_len = 32'(cfg_cut_ms) * 32'(TICKS_PER_MS);
      end else begin
        seq_phase = PH_COOL;
        cool_t0 = t.now;
      end
    end
    if (seq_phase == PH_CUT) begin
      o.flags = o.flags | CUT_MASK;
      elapsed = t.now - cut_t0;
      if (elapsed > cut_len) begin
        o.flags = o.flags & ~CUT_MASK;
        seq_phase = PH_COOL;
        cut_t0 = '0;
        cut_len = '0;
        cool_t0 = t.now;
      end
    end
    if (seq_phase == PH_COOL) begin
      // cooldown length is taken live, not latched
      cool_len = 32'(cfg_cool_ms) * 32'(TICKS_PER_MS);
      elapsed = t.now - cool_t0;
      if (elapsed > cool_len) begin
        seq_phase = PH_READY;
        cool_t0 = '0;
      end
    end
    o.phase = seq_phase;
    outcome_q.push_back(o);
  endfunction

  function automatic tick_t rand_tick();
    tick_t       t;
    logic [31:0] cut_thr;
    logic [31:0] cool_thr;
    logic [31:0] span;
    int          r;
    cut_thr = 32'(cfg_cut_ms) * 32'(TICKS_PER_MS);
    cool_thr = 32'(cfg_cool_ms) * 32'(TICKS_PER_MS);
    span = ((cut_thr > cool_thr) ? cut_thr : cool_thr) / 2 + 32'd2000;
    if ($urandom_range(0, 99) < 12) begin
      // noise: any field value, timer jumps anywhere
      t.speed = 16'($urandom);
      t.tps = 8'($urandom);
      t.gear = 8'($urandom);
      t.volt = 8'($urandom);
      gen_now = $urandom;
    end else begin
      case ($urandom_range(0, 9))
        0: ;
        1: gen_now += 32'd1;
        2: gen_now += cut_thr;
        3: gen_now += cool_thr + 32'd1;
        8: gen_now += $urandom;
        9: gen_now += $urandom_range(0, 5000);
        default: gen_now += $urandom_range(0, span);
      endcase
      case ($urandom_range(0, 4))
        0: t.speed = cfg_min_spd;
        1: t.speed = cfg_min_spd + 16'd1;
        2: t.speed = 16'($urandom);
        default: t.speed = 16'($urandom_range(cfg_min_spd, 16'hFFFF));
      endcase
      case ($urandom_range(0, 4))
        0: t.tps = cfg_min_thr;
        1: t.tps = cfg_min_thr - 8'd1;
        2: t.tps = 8'($urandom);
        default: t.tps = 8'($urandom_range(cfg_min_thr, 8'hFF));
      endcase
      r = $urandom_range(0, 9);
      if (r < 7) t.gear = 8'($urandom_range(0, 5));
      else if (r < 9) t.gear = 8'($urandom_range(6, 7));
      else t.gear = 8'($urandom);
      r = $urandom_range(0, 9);
      if (r < 5) t.volt = 8'($urandom_range(0, 15));
      else if (r == 5) t.volt = 8'd15;
      else if (r == 6) t.volt = 8'd16;
      else t.volt = 8'($urandom);
    end
    t.now = gen_now;
    t.flags = 8'($urandom);
    return t;
  endfunction

  task automatic add_tick(input logic [15:0] spd, input logic [7:0] tps, input logic [7:0] gear,
                          input logic [7:0] volt, input logic [31:0] dt,
                          input logic [7:0] fl);
    tick_t t;
    gen_now += dt;
    t.speed = spd;
    t.tps = tps;
    t.gear = gear;
    t.volt = volt;
    t.now = gen_now;
    t.flags = fl;
    tick_q.push_back(t);
  endtask

  task automatic add_random(input int n);
    repeat (n) tick_q.push_back(rand_tick());
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CUT_TIME:     cfg_cut_ms = val;
      CFG_COOLDOWN:     cfg_cool_ms = val;
      CFG_MIN_SPEED:    cfg_min_spd = val;
      CFG_MIN_THROTTLE: cfg_min_thr = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] cut_ms, input logic [15:0] cool_ms,
                          input logic [15:0] min_spd, input logic [7:0] min_thr);
    write_reg(CFG_CUT_TIME, cut_ms);
    write_reg(CFG_COOLDOWN, cool_ms);
    write_reg(CFG_MIN_SPEED, min_spd);
    // upper byte is don't-care for the throttle register
    write_reg(CFG_MIN_THROTTLE, {8'($urandom), min_thr});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // request driver
  tick_t cur_tick;
  int    in_wait = 0;
  bit    in_quiet = 1'b0;

  always @(posedge clk) begin : drv
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        sequence_tick(cur_tick);
        nv = 1'b0;
        if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
        in_wait = in_quiet ? 0 : $urandom_range(0, 18);
      end
      if (!nv) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (tick_q.size() > 0) begin
          cur_tick = tick_q.pop_front();
          in_engine_speed <= cur_tick.speed;
          in_throttle <= cur_tick.tps;
          in_gear <= cur_tick.gear;
          in_sensor_voltage <= cur_tick.volt;
          in_timer_now <= cur_tick.now;
          in_limit_flags_in <= cur_tick.flags;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // result monitor
  int out_wait = 0;
  int hold_cnt = 0;
  bit out_quiet = 1'b0;

  always @(posedge clk) begin : mon
    outcome_t want;
    logic     nr;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          err_cnt++;
          if (err_cnt < 40)
            $display("%0t: result with nothing pending: flags %02h phase %0d",
                     $time, out_limit_flags_out, out_phase);
        end else begin
          want = outcome_q.pop_front();
          if (out_limit_flags_out !== want.flags) begin
            err_cnt++;
            if (err_cnt < 40)
              $display("%0t: limit_flags_out expected %02h actual %02h",
                       $time, want.flags, out_limit_flags_out);
          end
          if (out_phase !== want.phase) begin
            err_cnt++;
            if (err_cnt < 40)
              $display("%0t: phase expected %0d actual %0d", $time, want.phase, out_phase);
          end
        end
        res_cnt++;
        // long back-pressure so the block fills up and stalls its input
        if (res_cnt == 400 || res_cnt == 1100) begin
          hold_cnt = 300;
        end else begin
          if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
          out_wait = out_quiet ? 0 : $urandom_range(0, 18);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        nr = 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_ready <= nr;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 700000-tick cut, 3000000-tick cooldown, speed 7680
    add_tick(16'd0, 8'd0, 8'd0, 8'd255, 32'd0, 8'hFF);
    add_tick(16'hFFFF, 8'hFF, 8'hFF, 8'd16, 32'd1, 8'h00);
    add_tick(16'd7680, 8'd0, 8'd0, 8'd15, 32'd0, 8'hAA);     // speed not above: reject
    add_tick(16'd7681, 8'd0, 8'd0, 8'd0, 32'd3000000, 8'h55); // timer wraps; elapsed equals: hold
    add_tick(16'd0, 8'd0, 8'd0, 8'd255, 32'd1, 8'h00);        // elapsed exceeds: cooldown ends
    add_tick(16'd7681, 8'd0, 8'd5, 8'd0, 32'd0, 8'hFC);       // cut starts
    add_tick(16'd7681, 8'd0, 8'd5, 8'd0, 32'd700000, 8'h00);
    add_tick(16'd7681, 8'd0, 8'd5, 8'd0, 32'd1, 8'hFF);       // cut ends
    add_tick(16'd0, 8'd0, 8'd0, 8'd255, 32'd3000001, 8'h0F);
    add_tick(16'hFFFF, 8'hFF, 8'd6, 8'd15, 32'd0, 8'h0F);     // gear too high
    add_tick(16'd0, 8'd0, 8'd0, 8'd255, 32'd3000001, 8'hF0);
    add_tick(16'hFFFF, 8'd128, 8'hFF, 8'd0, 32'd0, 8'h81);
    add_tick(16'd0, 8'd0, 8'd0, 8'd255, 32'hFFFF_FFFF, 8'h7E);
    add_tick(16'hFFFF, 8'hFF, 8'd0, 8'd0, 32'd0, 8'h3C);
    add_tick(16'hFFFF, 8'hFF, 8'd0, 8'd0, 32'h8000_0000, 8'hC3);
    add_tick(16'd0, 8'd0, 8'd0, 8'd255, 32'h8000_0000, 8'h18);
    wait_idle();

    // zero durations: still need the timer to move on
    set_regs(16'd0, 16'd0, 16'd0, 8'd0);
    add_tick(16'd0, 8'd0, 8'd0, 8'd255, 32'h7000_0000, 8'h00);
    add_tick(16'd0, 8'd0, 8'd0, 8'd255, 32'h7000_0000, 8'h00);
    add_tick(16'd1, 8'd0, 8'd0, 8'd0, 32'd0, 8'h00);
    add_tick(16'd1, 8'd0, 8'd0, 8'd0, 32'd0, 8'hA0);
    add_tick(16'd1, 8'd0, 8'd0, 8'd0, 32'd1, 8'hFF);
    add_tick(16'd1, 8'd0, 8'd0, 8'd0, 32'd0, 8'h01);
    add_tick(16'd1, 8'd0, 8'd0, 8'd0, 32'd1, 8'h02);
    add_tick(16'd0, 8'd0, 8'd0, 8'd0, 32'd0, 8'h04);
    add_random(150);
    wait_idle();

    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_random(120);
    wait_idle();

    set_regs(16'hFFFF, 16'd0, 16'd0, 8'd0);
    add_random(120);
    wait_idle();

    repeat (7) begin
      set_regs(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 200))
                                           : 16'($urandom_range(0, 3)),
               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 200))
                                           : 16'($urandom_range(0, 3)),
               16'($urandom),
               ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom));
      add_random(160);
      wait_idle();
    end

    repeat (5) @(posedge clk);
    if (err_cnt == 0 && outcome_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
